/* hw/rtl/sfr_pkg.sv */
package sfr_pkg;

   // Frame event codes reported with each result beat.
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_GOOD     = 3'd1;
   localparam logic [2:0] EV_SHORT    = 3'd2;
   localparam logic [2:0] EV_LENGTH   = 3'd3;
   localparam logic [2:0] EV_CRC      = 3'd4;
   localparam logic [2:0] EV_OVERFLOW = 3'd5;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_MARKER   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE_BYTE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_XOR_MASK     = 3'd3;

   // Register reset values.
   localparam logic [7:0] START_MARKER_RESET = 8'h02;
   localparam logic [7:0] END_MARKER_RESET   = 8'h03;
   localparam logic [7:0] ESCAPE_BYTE_RESET  = 8'h1B;
   localparam logic [7:0] XOR_MASK_RESET     = 8'h20;

   // CRC-16 constants and frame overhead (start, command, length, two CRC bytes, end).
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [8:0]  FRAME_OVERHEAD = 9'd6;

   // Depth of the queues between the front, the back and the result side.
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] escape_byte;
      logic [7:0] xor_mask;
   } cfg_type;

   // One classified input beat handed from the front to the back.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic [7:0] unstuffed;
      logic       is_start;
      logic       is_escape;
      logic       is_end;
   } front_beat_type;

   // One result beat.
   typedef struct packed {
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [8:0]  data_position;
      logic [2:0]  frame_event;
      logic [7:0]  frame_command;
      logic [7:0]  frame_length;
      logic [15:0] good_count;
      logic [15:0] error_count;
   } rsp_beat_type;

   // One byte of CRC-16 (poly 0x1021, MSB first).
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* hw/rtl/sfr_queue.sv */
module sfr_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNTW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0]   LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hw/rtl/sfr_front.sv */
module sfr_front
   import sfr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           push,
   input  logic [7:0]     rx_byte,
   output logic           full,
   input  logic           take,
   output front_beat_type beat,
   output logic           beat_empty
);

   front_beat_type classified;
   logic [$bits(front_beat_type)-1:0] queue_out;

   // Compare the raw byte against the markers and undo the stuffing mask in advance.
   always_comb begin
      classified.rx_byte   = rx_byte;
      classified.unstuffed = rx_byte ^ cfg.xor_mask;
      classified.is_start  = (rx_byte == cfg.start_marker);
      classified.is_escape = (rx_byte == cfg.escape_byte);
      classified.is_end    = (rx_byte == cfg.end_marker);
   end

   // Classified beats wait here until the back is free.
   sfr_queue #(
      .WIDTH ($bits(front_beat_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_in_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (classified),
      .full    (full),
      .pop     (take),
      .rd_data (queue_out),
      .empty   (beat_empty)
   );

   assign beat = front_beat_type'(queue_out);

endmodule

/* hw/rtl/sfr_back.sv */
module sfr_back
   import sfr_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 512
) (
   input  logic           clock,
   input  logic           reset,
   input  front_beat_type beat,
   input  logic           beat_empty,
   output logic           take,
   input  logic           rsp_pop,
   output logic           rsp_empty,
   output rsp_beat_type   rsp_beat
);

   localparam int unsigned CW   = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned CMPW = (CW > 9) ? CW : 9;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_FRAME_BYTES);
   localparam logic [CW-1:0] POS_ONE   = CW'(1);
   localparam logic [CW-1:0] POS_TWO   = CW'(2);
   localparam logic [CW-1:0] POS_THREE = CW'(3);

   logic          in_frame_ff, in_frame_in;
   logic          esc_pend_ff, esc_pend_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [7:0]    len_ff, len_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    lag_old_ff, lag_old_in;
   logic [7:0]    lag_new_ff, lag_new_in;
   logic [15:0]   good_ff, good_in;
   logic [15:0]   bad_ff, bad_in;

   logic          out_full;
   logic          fire;
   logic [7:0]    data_b;
   logic          end_hit;
   logic [CW-1:0] count_next;
   logic [CMPW-1:0] count_cmp;
   logic [CMPW-1:0] expect_cmp;
   logic [15:0]   rx_crc;
   rsp_beat_type  result;

   assign fire       = !beat_empty && !out_full;
   assign take       = fire;
   assign data_b     = esc_pend_ff ? beat.unstuffed : beat.rx_byte;
   assign end_hit    = !esc_pend_ff && beat.is_end;
   assign count_next = count_ff + 1'b1;
   assign count_cmp  = CMPW'(count_next);
   assign expect_cmp = CMPW'({1'b0, len_ff} + FRAME_OVERHEAD);
   assign rx_crc     = {lag_old_ff, lag_new_ff};

   // Frame engine: one beat per cycle from the front queue while a beat waits and the result queue has room.
   always_comb begin
      in_frame_in = in_frame_ff;
      esc_pend_in = esc_pend_ff;
      count_in    = count_ff;
      cmd_in      = cmd_ff;
      len_in      = len_ff;
      crc_in      = crc_ff;
      lag_old_in  = lag_old_ff;
      lag_new_in  = lag_new_ff;
      good_in     = good_ff;
      bad_in      = bad_ff;

      result.data_valid    = 1'b0;
      result.data_byte     = 8'h00;
      result.data_position = 9'd0;
      result.frame_event   = EV_NONE;

      if (!in_frame_ff) begin
         // Hunting: only the start marker opens a frame.
         if (beat.is_start) begin
            in_frame_in          = 1'b1;
            esc_pend_in          = 1'b0;
            count_in             = POS_ONE;
            cmd_in               = 8'h00;
            len_in               = 8'h00;
            crc_in               = CRC_INIT;
            lag_old_in           = 8'h00;
            lag_new_in           = 8'h00;
            result.data_valid    = 1'b1;
            result.data_byte     = beat.rx_byte;
         end
      end else if (!esc_pend_ff && beat.is_escape) begin
         esc_pend_in = 1'b1;
      end else begin
         esc_pend_in = 1'b0;
         if (count_ff >= MAX_COUNT) begin
            // No room for another byte.
            result.frame_event = EV_OVERFLOW;
            bad_in             = bad_ff + 1'b1;
            in_frame_in        = 1'b0;
         end else begin
            result.data_valid    = 1'b1;
            result.data_byte     = data_b;
            result.data_position = 9'(count_ff);
            count_in             = count_next;
            if (end_hit) begin
               // Frame check at the end marker.
               in_frame_in = 1'b0;
               if (count_cmp < CMPW'(FRAME_OVERHEAD)) begin
                  result.frame_event = EV_SHORT;
                  bad_in             = bad_ff + 1'b1;
               end else if (count_cmp != expect_cmp) begin
                  result.frame_event = EV_LENGTH;
                  bad_in             = bad_ff + 1'b1;
               end else if (rx_crc != crc_ff) begin
                  result.frame_event = EV_CRC;
                  bad_in             = bad_ff + 1'b1;
               end else begin
                  result.frame_event = EV_GOOD;
                  good_in            = good_ff + 1'b1;
               end
            end else begin
               // The CRC runs two bytes behind so that the CRC bytes stay out.
               if (count_ff == POS_ONE) begin
                  cmd_in = data_b;
               end
               if (count_ff == POS_TWO) begin
                  len_in = data_b;
               end
               if (count_ff >= POS_THREE) begin
                  crc_in = crc16_feed(crc_ff, lag_old_ff);
               end
               lag_old_in = lag_new_ff;
               lag_new_in = data_b;
            end
         end
      end

      result.frame_command = cmd_in;
      result.frame_length  = len_in;
      result.good_count    = good_in;
      result.error_count   = bad_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         esc_pend_ff <= 1'b0;
         count_ff    <= '0;
         cmd_ff      <= 8'h00;
         len_ff      <= 8'h00;
         crc_ff      <= CRC_INIT;
         lag_old_ff  <= 8'h00;
         lag_new_ff  <= 8'h00;
         good_ff     <= 16'h0000;
         bad_ff      <= 16'h0000;
      end else if (fire) begin
         in_frame_ff <= in_frame_in;
         esc_pend_ff <= esc_pend_in;
         count_ff    <= count_in;
         cmd_ff      <= cmd_in;
         len_ff      <= len_in;
         crc_ff      <= crc_in;
         lag_old_ff  <= lag_old_in;
         lag_new_ff  <= lag_new_in;
         good_ff     <= good_in;
         bad_ff      <= bad_in;
      end
   end

   // Finished result beats wait here for the receiver.
   sfr_queue #(
      .WIDTH ($bits(rsp_beat_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fire),
      .wr_data (result),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (rsp_beat),
      .empty   (rsp_empty)
   );

endmodule

/* hw/rtl/stuffed_frame_receiver_crc16.sv */
// Byte-stuffed frame receiver with CRC-16 check.
// Raw line bytes go in on the request queue: a beat is taken on a rising edge
// with push high and full low. Every byte gives exactly one result beat, which
// waits on the rsp_ ports while empty is low and is taken on an edge with pop
// high and empty low. The result carries the decoded byte and its position
// when one was stored, the frame event, the held command and length bytes and
// the good and error frame counters.
// An accepted byte waits in the input queue and is registered in the result queue
// before it shows on the rsp_ ports. While the result queue has room the block
// sustains one byte per cycle: the frame engine takes one beat from its input
// queue each cycle, with a byte-wide CRC update in that cycle. When the receiver
// stops popping, two result beats and two input beats are held in the queues
// before full rises; nothing is lost or repeated. Reset empties both queues,
// returns the receiver to hunting for a start marker, clears the counters and
// loads the marker registers with their default values. The csr_ port writes a
// register. The user writes only while the block is idle; the block does not check.
module stuffed_frame_receiver_crc16
   import sfr_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [7:0]             req_rx_byte,
   output logic                   empty,
   input  logic                   pop,
   output logic                   rsp_data_valid,
   output logic [7:0]             rsp_data_byte,
   output logic [8:0]             rsp_data_position,
   output logic [2:0]             rsp_frame_event,
   output logic [7:0]             rsp_frame_command,
   output logic [7:0]             rsp_frame_length,
   output logic [15:0]            rsp_good_count,
   output logic [15:0]            rsp_error_count,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   cfg_type        cfg_ff;
   front_beat_type beat;
   logic           beat_empty;
   logic           take;
   rsp_beat_type   rsp_beat;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker <= START_MARKER_RESET;
         cfg_ff.end_marker   <= END_MARKER_RESET;
         cfg_ff.escape_byte  <= ESCAPE_BYTE_RESET;
         cfg_ff.xor_mask     <= XOR_MASK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_MARKER: cfg_ff.start_marker <= csr_data;
            CSR_END_MARKER:   cfg_ff.end_marker   <= csr_data;
            CSR_ESCAPE_BYTE:  cfg_ff.escape_byte  <= csr_data;
            CSR_XOR_MASK:     cfg_ff.xor_mask     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Front: classify incoming bytes and queue them.
   sfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (push),
      .rx_byte    (req_rx_byte),
      .full       (full),
      .take       (take),
      .beat       (beat),
      .beat_empty (beat_empty)
   );

   // Back: frame engine and result queue.
   sfr_back #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .beat_empty (beat_empty),
      .take       (take),
      .rsp_pop    (pop),
      .rsp_empty  (empty),
      .rsp_beat   (rsp_beat)
   );

   assign rsp_data_valid    = rsp_beat.data_valid;
   assign rsp_data_byte     = rsp_beat.data_byte;
   assign rsp_data_position = rsp_beat.data_position;
   assign rsp_frame_event   = rsp_beat.frame_event;
   assign rsp_frame_command = rsp_beat.frame_command;
   assign rsp_frame_length  = rsp_beat.frame_length;
   assign rsp_good_count    = rsp_beat.good_count;
   assign rsp_error_count   = rsp_beat.error_count;

endmodule
